>>> rtl/jetp_pkg.sv
// shared types, constants and helpers of the julia escape-time pixel block
`default_nettype none
package jetp_pkg;

  // image and number format
  localparam int IMAGE_WIDTH   = 1024;
  localparam int IMAGE_HEIGHT  = 1024;
  localparam int FRACTION_BITS = 28;
  localparam int IMG_W_SHIFT   = $clog2(IMAGE_WIDTH);
  localparam int IMG_H_SHIFT   = $clog2(IMAGE_HEIGHT);

  // ln(2) in q30
  localparam logic [29:0] LN2_Q30 = 30'd744261117;

  // colour ramp
  localparam logic [31:0] WHITE      = 32'hFFFF_FFFF;
  localparam logic [7:0]  ALPHA      = 8'hFF;
  localparam logic [7:0]  BLUE_BASE  = 8'd55;
  localparam logic [7:0]  GREEN_BASE = 8'd42;
  localparam logic [7:0]  RED_BASE   = 8'd36;
  localparam logic [7:0]  BG_MUL     = 8'd200;
  localparam logic [7:0]  R_MUL      = 8'd170;
  localparam int          CH_MAX     = 255;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // divider width
  localparam int DIV_W = 32;

  // register indexes
  typedef enum logic [2:0] {
    REG_C_REAL      = 3'd0,
    REG_C_IMAG      = 3'd1,
    REG_ESC_RADIUS  = 3'd2,
    REG_ZOOM        = 3'd3,
    REG_OFFSET_REAL = 3'd4,
    REG_OFFSET_IMAG = 3'd5,
    REG_MAX_ITER    = 3'd6,
    REG_INV_LN_PWR  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] c_real;
    logic signed [31:0] c_imag;
    logic        [30:0] escape_radius;
    logic        [30:0] zoom_factor;
    logic signed [31:0] offset_real;
    logic signed [31:0] offset_imag;
    logic        [15:0] max_iterations;
    logic        [30:0] inv_ln_power;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] zx;
    logic signed [31:0] zy;
  } point_t;

  typedef enum logic [1:0] {F_IDLE, F_MX, F_MY, F_PUSH} front_state_t;

  typedef enum logic [4:0] {
    B_IDLE, B_SQX, B_SQY, B_TEST, B_XY, B_UPD,
    B_LN1S, B_LN1W, B_LN2S, B_LN2W, B_TERM, B_ADJ,
    B_D1S, B_D1W, B_D2S, B_D2W, B_OUT
  } back_state_t;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_FMUL, L_SUM, L_DONE} ln_state_t;

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/julia_escape_time_pixel.sv
// top level of the julia escape-time pixel block
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_pixel_x, in_pixel_y
//  out      output     out_valid / out_stall out_argb_color, out_iteration_count
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// the front maps a pixel in the states F_MX, F_MY and F_PUSH and queues up to 4 start points.
// the back steps each iteration through B_SQX, B_SQY, B_TEST, B_XY and B_UPD on its
// shared 32x32 multiplier; an escaped point then takes two log passes and two
// divides before its colour is out.
// reset is synchronous; it empties the queue, resets all sequencers and sets the registers to defaults.
// a stalled result holds in the back while the front keeps taking pixels until the queue is full.
`default_nettype none
module julia_escape_time_pixel import jetp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  in_pixel_x,
  input  wire logic [9:0]  in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_argb_color,
  output logic [15:0]      out_iteration_count
);

  cfg_t   cfg_r;
  logic   q_push, q_pop, q_full, q_empty;
  point_t q_wr, q_rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.c_real         <= -32'sd224143606;
      cfg_r.c_imag         <= 32'sd62303869;
      cfg_r.escape_radius  <= 31'd536870912;
      cfg_r.zoom_factor    <= 31'd268435456;
      cfg_r.offset_real    <= '0;
      cfg_r.offset_imag    <= '0;
      cfg_r.max_iterations <= 16'd100;
      cfg_r.inv_ln_power   <= 31'd387270501;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_C_REAL:      cfg_r.c_real         <= cfg_data;
        REG_C_IMAG:      cfg_r.c_imag         <= cfg_data;
        REG_ESC_RADIUS:  cfg_r.escape_radius  <= cfg_data[30:0];
        REG_ZOOM:        cfg_r.zoom_factor    <= cfg_data[30:0];
        REG_OFFSET_REAL: cfg_r.offset_real    <= cfg_data;
        REG_OFFSET_IMAG: cfg_r.offset_imag    <= cfg_data;
        REG_MAX_ITER:    cfg_r.max_iterations <= cfg_data[15:0];
        REG_INV_LN_PWR:  cfg_r.inv_ln_power   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  jetp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .q_push     (q_push),
    .q_data     (q_wr),
    .q_full     (q_full)
  );

  jetp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  jetp_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_empty             (q_empty),
    .q_data              (q_rd),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_argb_color      (out_argb_color),
    .out_iteration_count (out_iteration_count)
  );

endmodule
`default_nettype wire

>>> rtl/jetp_front.sv
// front part: takes a pixel and maps it to the complex start point
`default_nettype none
module jetp_front import jetp_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire cfg_t         cfg,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [9:0]   in_pixel_x,
  input  wire logic [9:0]   in_pixel_y,
  output logic              q_push,
  output point_t            q_data,
  input  wire logic         q_full
);

  localparam int SPAN_W = 62 - (FRACTION_BITS - 1);

  front_state_t state_r, state_nxt;
  logic [SPAN_W-1:0]     span_r;
  logic [61:0]           span_prod;
  logic [9:0]            px_r, py_r;
  logic signed [31:0]    zx_r, zy_r;
  logic [9:0]            pix_sel;
  logic [SPAN_W+9:0]     prod;
  logic [SPAN_W+9:0]     scaled;
  logic signed [31:0]    off_sel;
  logic signed [39:0]    coord_sum;

  // view span zoom*2r, follows the registers
  assign span_prod = 62'(cfg.zoom_factor) * 62'(cfg.escape_radius);

  // one coordinate per cycle through a shared multiplier
  always_comb begin
    pix_sel   = (state_r == F_MX) ? px_r : py_r;
    off_sel   = (state_r == F_MX) ? cfg.offset_real : cfg.offset_imag;
    prod      = (SPAN_W+10)'(pix_sel) * (SPAN_W+10)'(span_r);
    scaled    = (state_r == F_MX) ? (prod >> IMG_W_SHIFT) : (prod >> IMG_H_SHIFT);
    coord_sum = $signed(scaled[39:0]) - $signed({9'd0, cfg.escape_radius}) + 40'(off_sel);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (in_valid) state_nxt = F_MX;
      F_MX:    state_nxt = F_MY;
      F_MY:    state_nxt = F_PUSH;
      F_PUSH:  if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall = (state_r != F_IDLE);
    q_push   = (state_r == F_PUSH) && !q_full;
    q_data   = '{zx: zx_r, zy: zy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    span_r <= span_prod[61:FRACTION_BITS-1];
    if (state_r == F_IDLE && in_valid) begin
      px_r <= in_pixel_x;
      py_r <= in_pixel_y;
    end
    if (state_r == F_MX) zx_r <= sat32(coord_sum);
    if (state_r == F_MY) zy_r <= sat32(coord_sum);
  end

endmodule
`default_nettype wire

>>> rtl/jetp_fifo.sv
// short queue of start points between front and back
`default_nettype none
module jetp_fifo import jetp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire point_t wr_data,
  input  wire logic   pop,
  output point_t      rd_data,
  output logic        full,
  output logic        empty
);

  point_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAW:0]   cnt_r;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop && !empty) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule
`default_nettype wire

>>> rtl/jetp_ln.sv
// natural log unit, q30 result, by normalise and repeated squaring
`default_nettype none
module jetp_ln import jetp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] v,
  input  wire logic [6:0]  scale,
  output logic             done,
  output logic signed [39:0] res
);

  ln_state_t state_r, state_nxt;
  logic [63:0]        vn_r;
  logic [5:0]         k_r;
  logic [31:0]        m_r;
  logic [29:0]        f_r;
  logic [4:0]         bit_r;
  logic [29:0]        frac_r;
  logic [6:0]         scale_r;
  logic signed [39:0] res_r;
  logic [63:0]        sq;
  logic [59:0]        fprod;
  logic signed [7:0]  kd;
  logic signed [39:0] ipart;

  always_comb begin
    sq    = 64'(m_r) * 64'(m_r);
    fprod = 60'(f_r) * 60'(LN2_Q30);
    kd    = $signed({2'b00, k_r}) - $signed({1'b0, scale_r});
    ipart = 40'(kd) * $signed(40'(LN2_Q30));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE:  if (start) state_nxt = L_NORM;
      L_NORM:  if (vn_r[63]) state_nxt = L_SQ;
      L_SQ:    if (bit_r == 5'd0) state_nxt = L_FMUL;
      L_FMUL:  state_nxt = L_SUM;
      L_SUM:   state_nxt = L_DONE;
      L_DONE:  state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state_r == L_DONE);
    res  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          vn_r    <= (v == 64'd0) ? 64'd1 : v;
          k_r     <= 6'd63;
          scale_r <= scale;
          f_r     <= '0;
          bit_r   <= 5'd29;
        end
      end
      // leading one search, a byte or a bit a step
      L_NORM: begin
        if (vn_r[63]) begin
          m_r <= vn_r[63:32];
        end else if (vn_r[63:56] == 8'd0) begin
          vn_r <= vn_r << 8;
          k_r  <= k_r - 6'd8;
        end else begin
          vn_r <= vn_r << 1;
          k_r  <= k_r - 6'd1;
        end
      end
      // one fraction bit per squaring
      L_SQ: begin
        if (sq[63]) begin
          m_r        <= sq[63:32];
          f_r[bit_r] <= 1'b1;
        end else begin
          m_r <= sq[62:31];
        end
        bit_r <= bit_r - 5'd1;
      end
      L_FMUL: frac_r <= fprod[59:30];
      L_SUM:  res_r  <= ipart + $signed({10'd0, frac_r});
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/jetp_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module jetp_div import jetp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [15:0]      divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             busy_r, done_r;
  logic [CW-1:0]    cnt_r;
  logic [DIV_W-1:0] quo_r;
  logic [15:0]      rem_r;
  logic [16:0]      trial;
  logic             fits;

  assign trial    = {rem_r, quo_r[DIV_W-1]};
  assign fits     = (trial >= {1'b0, divisor});
  assign done     = done_r;
  assign quotient = quo_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r && start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (!busy_r && start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], fits};
      rem_r <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
    end
  end

endmodule
`default_nettype wire

>>> rtl/jetp_back.sv
// back part: iterates z = z*z + c, then smooth count and colour for escaped points, white for points inside
`default_nettype none
module jetp_back import jetp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  input  wire logic   q_empty,
  input  wire point_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output logic [31:0] out_argb_color,
  output logic [15:0] out_iteration_count
);

  back_state_t state_r, state_nxt;

  logic signed [31:0] zx_r, zy_r;
  logic [15:0]        cnt_r;
  logic signed [63:0] sqx_r, sqy_r, xy_r;
  logic [63:0]        mag_r;
  logic [61:0]        r2_r;
  logic signed [39:0] l1_r;
  logic signed [23:0] l2_r;
  logic signed [39:0] term_r;
  logic [17:0]        p_r;
  logic [31:0]        q1_r;
  logic [31:0]        argb_r;
  logic [15:0]        iter_r;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic [63:0]        mag;
  logic signed [63:0] dx_sh, xy_sh;
  logic signed [55:0] tprod;
  logic signed [39:0] adj;
  logic               ln_start, ln_done;
  logic [63:0]        ln_v;
  logic [6:0]         ln_scale;
  logic signed [39:0] ln_res;
  logic               div_start, div_done;
  logic [31:0]        div_dividend, div_q;

  // saturating colour channel
  function automatic logic [7:0] chan(input logic [31:0] q, input logic [7:0] base);
    logic [32:0] s;
    s = 33'(q) + 33'(base);
    return (s > 33'(CH_MAX)) ? 8'(CH_MAX) : s[7:0];
  endfunction

  jetp_ln u_ln (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ln_start),
    .v     (ln_v),
    .scale (ln_scale),
    .done  (ln_done),
    .res   (ln_res)
  );

  jetp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.max_iterations),
    .done     (div_done),
    .quotient (div_q)
  );

  // shared complex multiply and update terms
  always_comb begin
    mul_p = 64'(mul_a) * 64'(mul_b);
    mag   = $unsigned(sqx_r) + $unsigned(sqy_r);
    dx_sh = (sqx_r - sqy_r) >>> FRACTION_BITS;
    xy_sh = xy_r >>> (FRACTION_BITS - 1);
    tprod = 56'(l2_r) * $signed(56'(cfg.inv_ln_power));
    adj   = $signed(40'({cnt_r, 16'd0}) + 40'sd65536) - term_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_SQX;
      B_SQX:  state_nxt = B_SQY;
      B_SQY:  state_nxt = B_TEST;
      B_TEST: begin
        if (cnt_r == cfg.max_iterations) state_nxt = B_OUT;
        else if (mag < {2'b00, r2_r})    state_nxt = B_XY;
        else                             state_nxt = B_LN1S;
      end
      B_XY:   state_nxt = B_UPD;
      B_UPD:  state_nxt = B_SQX;
      B_LN1S: state_nxt = B_LN1W;
      B_LN1W: if (ln_done) state_nxt = B_LN2S;
      B_LN2S: state_nxt = B_LN2W;
      B_LN2W: if (ln_done) state_nxt = B_TERM;
      B_TERM: state_nxt = B_ADJ;
      B_ADJ:  state_nxt = B_D1S;
      B_D1S:  state_nxt = B_D1W;
      B_D1W:  if (div_done) state_nxt = B_D2S;
      B_D2S:  state_nxt = B_D2W;
      B_D2W:  if (div_done) state_nxt = B_OUT;
      B_OUT:  if (!out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop        = (state_r == B_IDLE) && !q_empty;
    mul_a        = (state_r == B_SQY) ? zy_r : zx_r;
    mul_b        = (state_r == B_SQX) ? zx_r : zy_r;
    ln_start     = (state_r == B_LN1S) || (state_r == B_LN2S);
    ln_v         = (state_r == B_LN1S) ? mag_r : 64'($unsigned(l1_r));
    ln_scale     = (state_r == B_LN1S) ? 7'(2 * FRACTION_BITS) : 7'd30;
    div_start    = (state_r == B_D1S) || (state_r == B_D2S);
    div_dividend = (state_r == B_D1S) ? 32'(p_r) * 32'(BG_MUL) : 32'(p_r) * 32'(R_MUL);
    out_valid    = (state_r == B_OUT);
    out_argb_color      = argb_r;
    out_iteration_count = iter_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    r2_r <= 62'(cfg.escape_radius) * 62'(cfg.escape_radius);
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          zx_r  <= q_data.zx;
          zy_r  <= q_data.zy;
          cnt_r <= '0;
        end
      end
      B_SQX: sqx_r <= mul_p;
      B_SQY: sqy_r <= mul_p;
      B_TEST: begin
        mag_r  <= mag;
        iter_r <= cnt_r;
        argb_r <= WHITE;
      end
      B_XY: xy_r <= mul_p;
      B_UPD: begin
        zx_r  <= sat32(40'(dx_sh) + 40'(cfg.c_real));
        zy_r  <= sat32(40'(xy_sh) + 40'(cfg.c_imag));
        cnt_r <= cnt_r + 16'd1;
      end
      // non-positive first log taken as one lsb
      B_LN1W: if (ln_done) l1_r <= (ln_res <= 40'sd0) ? 40'sd1 : ln_res;
      B_LN2W: if (ln_done) l2_r <= 24'(ln_res >>> 14);
      B_TERM: term_r <= 40'(tprod >>> FRACTION_BITS);
      B_ADJ:  p_r <= adj[39] ? 18'd0 : adj[33:16];
      B_D1W:  if (div_done) q1_r <= div_q;
      B_D2W: begin
        if (div_done) begin
          argb_r <= {ALPHA, chan(div_q, RED_BASE), chan(q1_r, GREEN_BASE),
                     chan(q1_r, BLUE_BASE)};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sim/tb_julia_escape_time_pixel.sv
// testbench for the julia escape-time pixel block: directed table, random phases, self-checking
`timescale 1ns / 100ps
`default_nettype none
module tb_julia_escape_time_pixel;
  import jetp_pkg::*;

  localparam int  ITEMS_PER_PHASE = 96;
  localparam int  NUM_PHASES      = 12;
  localparam int  STALL_LIMIT     = 1500000;
  localparam int  DRAIN_CYCLES    = 16;
  localparam logic [31:0] S32_TOP = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_BOT = 32'h8000_0000;

  typedef struct {
    logic [31:0] argb;
    logic [15:0] iters;
  } pixel_result_t;

  typedef struct {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [15:0] limit;
    bit          known;
    logic [31:0] argb;
    logic [15:0] iters;
  } pixel_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [9:0]  in_pixel_x;
  logic [9:0]  in_pixel_y;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_argb_color;
  logic [15:0] out_iteration_count;

  cfg_t          view_cfg;
  pixel_result_t pending_pixels[$];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches;
  int            pixels_checked;
  int            white_pixels;
  int            quiet_cycles;

  julia_escape_time_pixel DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_x          (in_pixel_x),
    .in_pixel_y          (in_pixel_y),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_argb_color      (out_argb_color),
    .out_iteration_count (out_iteration_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // clamp to signed 32-bit range
  function automatic longint clamp32(input longint v);
    if (v > longint'(S32_TOP)) begin
      return longint'(S32_TOP);
    end
    if (v < -longint'(S32_BOT)) begin
      return -longint'(S32_BOT);
    end
    return v;
  endfunction

  // natural log of v / 2^scale in q30, fraction by repeated squaring
  function automatic longint log_q30(input logic [63:0] v, input int scale);
    logic [63:0] m;
    logic [63:0] f;
    int k;
    if (v == 64'd0) begin
      v = 64'd1;
    end
    k = 63;
    while (k > 0 && v[k] == 1'b0) k--;
    m = (k >= 31) ? (v >> (k - 31)) : (v << (31 - k));
    f = '0;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f[b] = 1'b1;
      end
    end
    return longint'(k - scale) * longint'(LN2_Q30) + longint'((f * 64'(LN2_Q30)) >> 30);
  endfunction

  // one colour channel of the ramp, saturating
  function automatic logic [7:0] ramp_channel(input logic [63:0] p, input logic [63:0] mul,
                                              input logic [63:0] base, input logic [63:0] lim);
    logic [63:0] v;
    v = (p * mul) / lim + base;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  // escape-time colour and count of one pixel under the current view
  function automatic pixel_result_t escape_pixel(input logic [9:0] px, input logic [9:0] py);
    pixel_result_t res;
    logic [63:0] span, r2, mag, iters, level;
    longint r, zx, zy, nx, ny, l1, l2, adj;
    r = longint'(64'(view_cfg.escape_radius));
    span = (64'(view_cfg.zoom_factor) * 64'(view_cfg.escape_radius)) >> (FRACTION_BITS - 1);
    zx = clamp32(longint'((64'(px) * span) >> IMG_W_SHIFT) - r + longint'(view_cfg.offset_real));
    zy = clamp32(longint'((64'(py) * span) >> IMG_H_SHIFT) - r + longint'(view_cfg.offset_imag));
    r2 = 64'(r * r);
    mag = 64'(zx * zx) + 64'(zy * zy);
    iters = '0;
    // z = z^2 + c until escape or limit
    while (mag < r2 && iters < 64'(view_cfg.max_iterations)) begin
      nx = clamp32(((zx * zx - zy * zy) >>> FRACTION_BITS) + longint'(view_cfg.c_real));
      ny = clamp32(((zx * zy) >>> (FRACTION_BITS - 1)) + longint'(view_cfg.c_imag));
      zx = nx;
      zy = ny;
      mag = 64'(zx * zx) + 64'(zy * zy);
      iters++;
    end
    res.iters = iters[15:0];
    if (iters == 64'(view_cfg.max_iterations)) begin
      res.argb = WHITE;
      return res;
    end
    // smoothed count
    l1 = log_q30(mag, 2 * FRACTION_BITS);
    if (l1 <= 0) begin
      l1 = 1;
    end
    l2 = log_q30(64'(l1), 30) >>> 14;
    adj = longint'((iters + 64'd1) << 16)
        - ((l2 * longint'(64'(view_cfg.inv_ln_power))) >>> FRACTION_BITS);
    if (adj < 0) begin
      adj = 0;
    end
    level = 64'(adj) >> 16;
    res.argb = {ALPHA,
                ramp_channel(level, 64'(R_MUL), 64'(RED_BASE), 64'(view_cfg.max_iterations)),
                ramp_channel(level, 64'(BG_MUL), 64'(GREEN_BASE), 64'(view_cfg.max_iterations)),
                ramp_channel(level, 64'(BG_MUL), 64'(BLUE_BASE), 64'(view_cfg.max_iterations))};
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch on %s: expected %h, got %h (pixel %0d)", what, want, got, pixels_checked);
    mismatches++;
  endtask

  // one register write, also kept in the local view; the last of a burst drops the enable
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] d, input bit last);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_C_REAL:      view_cfg.c_real         = d;
      REG_C_IMAG:      view_cfg.c_imag         = d;
      REG_ESC_RADIUS:  view_cfg.escape_radius  = d[30:0];
      REG_ZOOM:        view_cfg.zoom_factor    = d[30:0];
      REG_OFFSET_REAL: view_cfg.offset_real    = d;
      REG_OFFSET_IMAG: view_cfg.offset_imag    = d;
      REG_MAX_ITER:    view_cfg.max_iterations = d[15:0];
      default:         view_cfg.inv_ln_power   = d[30:0];
    endcase
    @(posedge clk);
    if (last) begin
      cfg_we <= 1'b0;
    end
  endtask

  task automatic write_view(input cfg_t v);
    write_reg(REG_C_REAL, v.c_real, 1'b0);
    write_reg(REG_C_IMAG, v.c_imag, 1'b0);
    write_reg(REG_ESC_RADIUS, {1'b0, v.escape_radius}, 1'b0);
    write_reg(REG_ZOOM, {1'b0, v.zoom_factor}, 1'b0);
    write_reg(REG_OFFSET_REAL, v.offset_real, 1'b0);
    write_reg(REG_OFFSET_IMAG, v.offset_imag, 1'b0);
    write_reg(REG_MAX_ITER, {16'd0, v.max_iterations}, 1'b0);
    write_reg(REG_INV_LN_PWR, {1'b0, v.inv_ln_power}, 1'b1);
  endtask

  // wait until every expected pixel is back, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one pixel transfer on the input channel
  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y, input bit known,
                            input pixel_result_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    pending_pixels.push_back(known ? typed : escape_pixel(x, y));
  endtask

  function automatic cfg_t random_view();
    cfg_t v;
    v.c_real         = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    v.c_imag         = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    v.escape_radius  = ($urandom_range(0, 1) == 0) ? 31'h2000_0000
                                                   : 31'($urandom_range(32'h0800_0000, 32'h4000_0000));
    v.zoom_factor    = 31'($urandom_range(32'h0400_0000, 32'h2000_0000));
    v.offset_real    = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
    v.offset_imag    = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
    v.max_iterations = 16'($urandom_range(2, 150));
    v.inv_ln_power   = 31'($urandom_range(0, 32'h2000_0000));
    return v;
  endfunction

  // result checking, receiver stalls and watchdog
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", '0, out_argb_color);
      end else begin
        want = pending_pixels.pop_front();
        if (out_argb_color !== want.argb) begin
          report_mismatch("argb_color", want.argb, out_argb_color);
        end
        if (out_iteration_count !== want.iters) begin
          report_mismatch("iteration_count", 32'(want.iters), 32'(out_iteration_count));
        end
        if (want.argb == WHITE) begin
          white_pixels++;
        end
      end
      pixels_checked++;
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    pixel_row_t    rows[$];
    pixel_result_t none;
    cfg_t          v;
    none = '{argb: '0, iters: '0};
    mismatches = 0;
    pixels_checked = 0;
    white_pixels = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_C_REAL;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    out_stall  <= 1'b0;
    view_cfg = '{c_real: -32'sd224143606, c_imag: 32'sd62303869, escape_radius: 31'd536870912,
                 zoom_factor: 31'd268435456, offset_real: '0, offset_imag: '0,
                 max_iterations: 16'd100, inv_ln_power: 31'd387270501};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: corners, centre, three inner points, then limit of zero, one and the maximum
    rows = '{
      '{10'd0,    10'd0,    16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd1023, 10'd1023, 16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd0,    10'd1023, 16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd1023, 10'd0,    16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd512,  10'd512,  16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd600,  10'd400,  16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd300,  10'd700,  16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd682,  10'd341,  16'd100,   1'b0, 32'h0, 16'd0},
      '{10'd512,  10'd512,  16'd0,     1'b1, WHITE, 16'd0},
      '{10'd0,    10'd0,    16'd0,     1'b1, WHITE, 16'd0},
      '{10'd1023, 10'd1023, 16'd0,     1'b1, WHITE, 16'd0},
      '{10'd512,  10'd512,  16'd1,     1'b1, WHITE, 16'd1},
      '{10'd0,    10'd0,    16'd1,     1'b0, 32'h0, 16'd0},
      '{10'd0,    10'd0,    16'd65535, 1'b0, 32'h0, 16'd0},
      '{10'd1023, 10'd1023, 16'd65535, 1'b0, 32'h0, 16'd0},
      '{10'd1023, 10'd0,    16'd65535, 1'b0, 32'h0, 16'd0}
    };
    foreach (rows[i]) begin
      if (rows[i].limit != view_cfg.max_iterations) begin
        wait_drained();
        write_reg(REG_MAX_ITER, {16'd0, rows[i].limit}, 1'b1);
      end
      send_pixel(rows[i].x, rows[i].y, rows[i].known,
                 '{argb: rows[i].argb, iters: rows[i].iters});
    end

    // random phases, each under its own view; the first few hit register extremes
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      v = random_view();
      case (p)
        0: begin
          v.c_real = S32_BOT; v.c_imag = S32_TOP;
          v.offset_real = S32_TOP; v.offset_imag = S32_BOT;
        end
        1: v.escape_radius = '0;
        2: begin
          v.escape_radius = '1; v.zoom_factor = '1; v.max_iterations = 16'd12;
        end
        3: begin
          v.zoom_factor = '0; v.inv_ln_power = '1;
        end
        4: begin
          v.inv_ln_power = '0; v.c_real = S32_TOP; v.c_imag = S32_BOT;
          v.offset_real = S32_BOT; v.offset_imag = S32_TOP;
        end
        5: v.max_iterations = 16'd1;
        default: ;
      endcase
      write_view(v);
      send_idle_pct = (p < 4) ? 9 : (p < 8) ? 77 : 0;
      recv_idle_pct = (p < 4) ? 77 : (p < 8) ? 9 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds off once per phase until the block is empty
        if (n == ITEMS_PER_PHASE / 2) begin
          wait_drained();
        end
        send_pixel(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), 1'b0, none);
      end
    end

    wait_drained();
    $display("covered %0d pixels (%0d inside) over %0d views incl. register extremes",
             pixels_checked, white_pixels, NUM_PHASES + 1);
    $display("limits of zero, one and 65535, with and without stalls on both sides");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
